// ===== hw/rtl/ritoa_pkg.sv =====
// Shared constants and helpers for the radix integer-to-ASCII converter.
package ritoa_pkg;

  localparam int VALUE_WIDTH = 32;

  // Divider works on a chunk of dividend bits per cycle.
  localparam int DIV_CHUNK  = 8;
  localparam int DIV_STEPS  = (VALUE_WIDTH + DIV_CHUNK - 1) / DIV_CHUNK;
  localparam int DIV_WIDTH  = DIV_STEPS * DIV_CHUNK;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  localparam int ADDR_W     = $clog2(VALUE_WIDTH);
  localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

  localparam int RADIX_W    = 5;
  localparam int FLAGS_W    = 2;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 1'b1;

  localparam int FLAG_UNSIGNED = 0;
  localparam int FLAG_LOWER    = 1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic lower);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + d_ext;
    end else if (lower) begin
      return CHAR_LOWER + d_ext - 8'd10;
    end else begin
      return CHAR_UPPER + d_ext - 8'd10;
    end
  endfunction

endpackage

// ===== hw/rtl/ritoa_div.sv =====
// Radix divider slice: one chunk of dividend bits against a base of 2 to 16.
module ritoa_div (
  input  logic [ritoa_pkg::DIGIT_W-1:0]   rem_in,
  input  logic [ritoa_pkg::DIV_CHUNK-1:0] dividend,
  input  logic [ritoa_pkg::RADIX_W-1:0]   base,
  output logic [ritoa_pkg::DIV_CHUNK-1:0] quotient,
  output logic [ritoa_pkg::DIGIT_W-1:0]   rem_out
);

  always_comb begin
    logic [ritoa_pkg::DIGIT_W-1:0] rem;
    logic [ritoa_pkg::RADIX_W-1:0] trial;
    rem      = rem_in;
    quotient = '0;
    // restoring division, MSB first; remainder stays below base
    for (int i = ritoa_pkg::DIV_CHUNK - 1; i >= 0; i--) begin
      trial = {rem, dividend[i]};
      if (trial >= base) begin
        trial       = trial - base;
        quotient[i] = 1'b1;
      end
      rem = trial[ritoa_pkg::DIGIT_W-1:0];
    end
    rem_out = rem;
  end

endmodule

// ===== hw/rtl/radix_integer_to_ascii_top.sv =====
// Radix integer-to-ASCII converter: top level with sequencer, digit memory and output register.
//
// Converts one value to text in the radix held in register 0 (2 to 16, out-of-range values
// saturate) and sends it one ASCII character per transfer, most significant first, with
// last_char marking the final character. Register 1 bit 0 selects unsigned interpretation,
// bit 1 selects lowercase letters. Each digit takes one pass of the value through the shared
// divider, 8 quotient bits per cycle, and its remainder goes into the digit memory. The top
// digit is then read (a leading minus, if any, goes out in that same cycle), one character per
// cycle follows while the output is not stalled, and the sequencer returns to idle for the
// next value. A new value is taken once the last character has entered the output register.
module radix_integer_to_ascii_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ritoa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ritoa_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [ritoa_pkg::VALUE_WIDTH-1:0] value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ritoa_pkg::CHAR_W-1:0]         character,
  output logic                                 last_char
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_FETCH,
    ST_EMIT
  } state_t;

  state_t                              state;
  logic [ritoa_pkg::RADIX_W-1:0]       radix;
  logic [ritoa_pkg::FLAGS_W-1:0]       format_flags;
  logic                                negative;
  logic [ritoa_pkg::DIV_WIDTH-1:0]     quot;
  logic [ritoa_pkg::DIGIT_W-1:0]       rem;
  logic [ritoa_pkg::STEP_W-1:0]        step;
  logic [ritoa_pkg::CNT_W-1:0]         count;
  logic [ritoa_pkg::ADDR_W-1:0]        rd_addr;
  logic [ritoa_pkg::ADDR_W-1:0]        rd_addr_next;
  logic [ritoa_pkg::DIGIT_W-1:0]       rd_data;
  logic [ritoa_pkg::DIGIT_W-1:0]       digit_mem [ritoa_pkg::VALUE_WIDTH];

  logic [ritoa_pkg::RADIX_W-1:0]       base;
  logic [ritoa_pkg::DIV_CHUNK-1:0]     div_q;
  logic [ritoa_pkg::DIGIT_W-1:0]       div_rem;
  logic [ritoa_pkg::DIV_WIDTH-1:0]     quot_shift;
  logic                                last_step;
  logic                                load_ok;
  logic                                out_load;
  logic                                in_neg;
  logic [ritoa_pkg::VALUE_WIDTH-1:0]   in_mag;

  always_comb begin
    if (radix < ritoa_pkg::RADIX_MIN) begin
      base = ritoa_pkg::RADIX_MIN;
    end else if (radix > ritoa_pkg::RADIX_MAX) begin
      base = ritoa_pkg::RADIX_MAX;
    end else begin
      base = radix;
    end
  end

  ritoa_div u_div (
    .rem_in   (rem),
    .dividend (quot[ritoa_pkg::DIV_WIDTH-1 -: ritoa_pkg::DIV_CHUNK]),
    .base     (base),
    .quotient (div_q),
    .rem_out  (div_rem)
  );

  assign quot_shift = (quot << ritoa_pkg::DIV_CHUNK)
                    | ritoa_pkg::DIV_WIDTH'(div_q);
  assign last_step  = (step == ritoa_pkg::STEP_W'(ritoa_pkg::DIV_STEPS - 1));
  assign load_ok    = !out_valid || !out_stall;
  assign out_load   = (state == ST_SIGN || state == ST_EMIT) && load_ok;
  assign in_stall   = (state != ST_IDLE);

  assign in_neg = !format_flags[ritoa_pkg::FLAG_UNSIGNED] && value[ritoa_pkg::VALUE_WIDTH-1];
  assign in_mag = in_neg ? (~value + 1'b1) : value;

  // prefetch the next digit while emitting
  assign rd_addr_next = (state == ST_EMIT && load_ok) ? (rd_addr - 1'b1) : rd_addr;

  always_ff @(posedge clk) begin
    if (state == ST_DIVIDE && last_step) begin
      digit_mem[count[ritoa_pkg::ADDR_W-1:0]] <= div_rem;
    end
    rd_data <= digit_mem[rd_addr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      radix        <= ritoa_pkg::RADIX_RESET;
      format_flags <= '0;
      out_valid    <= 1'b0;
      count        <= '0;
      quot         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ritoa_pkg::REG_RADIX:  radix        <= cfg_data;
          ritoa_pkg::REG_FORMAT: format_flags <= cfg_data[ritoa_pkg::FLAGS_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            negative <= in_neg;
            quot     <= ritoa_pkg::DIV_WIDTH'(in_mag);
            rem      <= '0;
            step     <= '0;
            count    <= '0;
            state    <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          quot <= quot_shift;
          if (last_step) begin
            rem     <= '0;
            step    <= '0;
            count   <= count + 1'b1;
            rd_addr <= count[ritoa_pkg::ADDR_W-1:0];
            if (quot_shift == '0) begin
              state <= negative ? ST_SIGN : ST_FETCH;
            end
          end else begin
            rem  <= div_rem;
            step <= step + 1'b1;
          end
        end
        ST_SIGN: begin
          if (load_ok) begin
            character <= ritoa_pkg::CHAR_MINUS;
            last_char <= 1'b0;
            state     <= ST_EMIT;
          end
        end
        ST_FETCH: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load_ok) begin
            character <= ritoa_pkg::digit_char(rd_data,
                                               format_flags[ritoa_pkg::FLAG_LOWER]);
            last_char <= (count == ritoa_pkg::CNT_W'(1));
            count     <= count - 1'b1;
            rd_addr   <= rd_addr_next;
            if (count == ritoa_pkg::CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
